[rtl/core/pscc_pkg.sv]
// Shared types, constants and the microcode table for the clamped PI speed controller.
// No dependencies; used by pscc_datapath and pi_speed_controller_clamped_unit.
package pscc_pkg;

  localparam int ENC_W    = 16;
  localparam int TGT_W    = 8;
  localparam int DRIVE_W  = 9;
  localparam int PGAIN_W  = 16;
  localparam int IGAIN_W  = 20;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 1;
  localparam int INTEG_W  = 25;
  localparam int ERR_W    = 22;
  localparam int MUL_A_W  = 21;
  localparam int MUL_B_W  = 22;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int P16_W    = 38;
  localparam int WIDE_W   = 39;
  localparam int STEP_W   = 3;

  // Reciprocal of the speed divisor: floor(n/13) == (n*80660)>>20 for n < 2^18
  localparam logic signed [MUL_A_W-1:0] RECIP_13 = 21'sd80660;
  localparam int RECIP_SHIFT = 20;
  localparam logic signed [INTEG_W-1:0] LIMIT_Q16 = 25'sd16711680;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 1'd1;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_DIV   = 3'd1;
  localparam step_t ST_ERR   = 3'd2;
  localparam step_t ST_PMUL  = 3'd3;
  localparam step_t ST_IMUL  = 3'd4;
  localparam step_t ST_INTEG = 3'd5;
  localparam step_t ST_OUT   = 3'd6;

  typedef enum logic [1:0] {
    ASEL_RECIP,
    ASEL_PGAIN,
    ASEL_IGAIN
  } asel_t;

  typedef enum logic {
    BSEL_ABS,
    BSEL_ERR
  } bsel_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_t;

  typedef struct packed {
    step_t next;
    hold_t hold;
    asel_t a_sel;
    bsel_t b_sel;
    logic  ld_prod;
    logic  ld_err;
    logic  ld_p16;
    logic  ld_integ;
    logic  ld_out;
  } ucode_t;

  typedef struct packed {
    logic  ld_in;
    asel_t a_sel;
    bsel_t b_sel;
    logic  ld_prod;
    logic  ld_err;
    logic  ld_p16;
    logic  ld_integ;
    logic  ld_out;
  } dp_ctrl_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{next: ST_IDLE, hold: HOLD_NONE, a_sel: ASEL_RECIP, b_sel: BSEL_ABS,
          ld_prod: 1'b0, ld_err: 1'b0, ld_p16: 1'b0, ld_integ: 1'b0, ld_out: 1'b0};
    case (s)
      ST_IDLE: begin
        w.next = ST_DIV;
        w.hold = HOLD_IN;
      end
      ST_DIV: begin
        w.next    = ST_ERR;
        w.a_sel   = ASEL_RECIP;
        w.b_sel   = BSEL_ABS;
        w.ld_prod = 1'b1;
      end
      ST_ERR: begin
        w.next   = ST_PMUL;
        w.ld_err = 1'b1;
      end
      ST_PMUL: begin
        w.next    = ST_IMUL;
        w.a_sel   = ASEL_PGAIN;
        w.b_sel   = BSEL_ERR;
        w.ld_prod = 1'b1;
      end
      ST_IMUL: begin
        w.next    = ST_INTEG;
        w.a_sel   = ASEL_IGAIN;
        w.b_sel   = BSEL_ERR;
        w.ld_prod = 1'b1;
        w.ld_p16  = 1'b1;
      end
      ST_INTEG: begin
        w.next     = ST_OUT;
        w.ld_integ = 1'b1;
      end
      ST_OUT: begin
        w.next   = ST_IDLE;
        w.hold   = HOLD_OUT;
        w.ld_out = 1'b1;
      end
      default: begin
        w.next = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [INTEG_W-1:0] clamp_q16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] lim;
    lim = {{(WIDE_W-INTEG_W){LIMIT_Q16[INTEG_W-1]}}, LIMIT_Q16};
    if (v > lim) begin
      return LIMIT_Q16;
    end else if (v < -lim) begin
      return -LIMIT_Q16;
    end else begin
      return v[INTEG_W-1:0];
    end
  endfunction

endpackage

[rtl/core/pi_speed_controller_clamped_unit.sv]
// Clamped PI speed controller, microcoded: a seven-step program steps one shared multiplier.
// Sequence: input accepted in idle, then DIV, ERR, PMUL, IMUL, INTEG and OUT, which registers
// the drive and raises out_valid, stalling while an earlier result is unaccepted. No new input
// is taken before idle. Three of the seven steps are passes through the shared multiplier.
// Reset (rst_n low, synchronous): gains and integrator clear, program returns to idle.
// Depends on pscc_pkg and pscc_datapath.
module pi_speed_controller_clamped_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pscc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pscc_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pscc_pkg::ENC_W-1:0]   in_encoder_count,
  input  logic signed [pscc_pkg::TGT_W-1:0]   in_target,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pscc_pkg::DRIVE_W-1:0] out_drive
);
  import pscc_pkg::*;

  step_t    step_r;
  step_t    step_nxt;
  logic     out_valid_r;
  logic     out_valid_nxt;
  ucode_t   uw;
  logic     held;
  dp_ctrl_t ctrl;

  always_comb begin
    uw = ucode_rom(step_r);
    case (uw.hold)
      HOLD_IN:  held = !in_valid;
      HOLD_OUT: held = out_valid_r && !out_ready;
      default:  held = 1'b0;
    endcase
    in_ready = (uw.hold == HOLD_IN);
    step_nxt = held ? step_r : uw.next;

    ctrl.ld_in    = in_valid && in_ready;
    ctrl.a_sel    = uw.a_sel;
    ctrl.b_sel    = uw.b_sel;
    ctrl.ld_prod  = uw.ld_prod && !held;
    ctrl.ld_err   = uw.ld_err && !held;
    ctrl.ld_p16   = uw.ld_p16 && !held;
    ctrl.ld_integ = uw.ld_integ && !held;
    ctrl.ld_out   = uw.ld_out && !held;

    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.ld_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  pscc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_encoder_count (in_encoder_count),
    .in_target        (in_target),
    .drive            (out_drive)
  );

  assign out_valid = out_valid_r;

endmodule

[rtl/core/pscc_datapath.sv]
// Datapath of the clamped PI speed controller: gain registers, shared multiplier,
// error, integrator and drive registers. Driven by the control word from the sequencer.
// Depends on pscc_pkg.
module pscc_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pscc_pkg::dp_ctrl_t               ctrl,
  input  logic                             cfg_we,
  input  logic [pscc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pscc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic signed [pscc_pkg::ENC_W-1:0] in_encoder_count,
  input  logic signed [pscc_pkg::TGT_W-1:0] in_target,
  output logic signed [pscc_pkg::DRIVE_W-1:0] drive
);
  import pscc_pkg::*;

  logic [PGAIN_W-1:0]             pgain_r;
  logic [IGAIN_W-1:0]             igain_r;
  logic                           neg_r;
  logic [ENC_W:0]                 abs_r;
  logic signed [TGT_W-1:0]        tgt_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [ERR_W-1:0]        err_r;
  logic signed [P16_W-1:0]        p16_r;
  logic signed [INTEG_W-1:0]      integ_r;
  logic signed [DRIVE_W-1:0]      drive_r;

  logic signed [ENC_W:0]          enc_x;
  logic [ENC_W:0]                 abs_nxt;
  logic signed [MUL_A_W-1:0]      mul_a;
  logic signed [MUL_B_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]       prod_nxt;
  logic [11:0]                    quot;
  logic signed [ERR_W-1:0]        meas;
  logic signed [ERR_W-1:0]        tgt_x;
  logic signed [ERR_W-1:0]        err_nxt;
  logic signed [PROD_W-1:0]       prod_rnd;
  logic signed [WIDE_W-1:0]       inc_x;
  logic signed [WIDE_W-1:0]       integ_x;
  logic signed [WIDE_W-1:0]       p16_x;
  logic signed [INTEG_W-1:0]      integ_nxt;
  logic signed [INTEG_W-1:0]      sum_c;
  logic signed [INTEG_W:0]        sum_adj;

  always_comb begin
    enc_x   = {in_encoder_count[ENC_W-1], in_encoder_count};
    abs_nxt = enc_x[ENC_W] ? (ENC_W+1)'(-enc_x) : (ENC_W+1)'(enc_x);
  end

  always_comb begin
    case (ctrl.a_sel)
      ASEL_RECIP: mul_a = RECIP_13;
      ASEL_PGAIN: mul_a = {{(MUL_A_W-PGAIN_W){1'b0}}, pgain_r};
      ASEL_IGAIN: mul_a = {{(MUL_A_W-IGAIN_W){1'b0}}, igain_r};
      default:    mul_a = '0;
    endcase
    case (ctrl.b_sel)
      BSEL_ABS: mul_b = {{(MUL_B_W-ENC_W-1){1'b0}}, abs_r};
      BSEL_ERR: mul_b = err_r;
      default:  mul_b = '0;
    endcase
    prod_nxt = {{MUL_B_W{mul_a[MUL_A_W-1]}}, mul_a} * {{MUL_A_W{mul_b[MUL_B_W-1]}}, mul_b};
  end

  always_comb begin
    quot    = prod_r[RECIP_SHIFT+11:RECIP_SHIFT];
    meas    = neg_r ? -ERR_W'(quot) : ERR_W'(quot);
    tgt_x   = {{(ERR_W-TGT_W){tgt_r[TGT_W-1]}}, tgt_r};
    err_nxt = (tgt_x <<< 9) + (tgt_x <<< 7) + (tgt_x <<< 2) + tgt_x - (meas <<< 8);
  end

  always_comb begin
    prod_rnd  = prod_r + (prod_r[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    inc_x     = {{(WIDE_W-PROD_W+8){prod_rnd[PROD_W-1]}}, prod_rnd[PROD_W-1:8]};
    integ_x   = {{(WIDE_W-INTEG_W){integ_r[INTEG_W-1]}}, integ_r};
    integ_nxt = clamp_q16(integ_x + inc_x);
    p16_x     = {{(WIDE_W-P16_W){p16_r[P16_W-1]}}, p16_r};
    sum_c     = clamp_q16(p16_x + integ_x);
    sum_adj   = {sum_c[INTEG_W-1], sum_c} +
                (sum_c[INTEG_W-1] ? (INTEG_W+1)'(65535) : (INTEG_W+1)'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pgain_r <= '0;
      igain_r <= '0;
      integ_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:  pgain_r <= cfg_wdata[PGAIN_W-1:0];
          REG_INTEG_GAIN: igain_r <= cfg_wdata[IGAIN_W-1:0];
          default: begin
          end
        endcase
      end
      if (ctrl.ld_integ) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      neg_r <= in_encoder_count[ENC_W-1];
      abs_r <= abs_nxt;
      tgt_r <= in_target;
    end
    if (ctrl.ld_prod) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.ld_err) begin
      err_r <= err_nxt;
    end
    if (ctrl.ld_p16) begin
      p16_r <= prod_r[P16_W-1:0];
    end
    if (ctrl.ld_out) begin
      drive_r <= sum_adj[INTEG_W-1:16];
    end
  end

  assign drive = drive_r;

endmodule
